>>> rtl/plf_pkg.sv
package plf_pkg;

	localparam int ACTION_W = 2;
	localparam int SAMPLE_W = 24;
	localparam int INDEX_W  = 8;
	localparam int COEF_W   = 18;
	localparam int OUT_W    = 32;
	localparam int TAP_W    = 9;
	localparam int PROD_W   = SAMPLE_W + COEF_W;

	localparam logic [TAP_W-1:0] TAP_RESET = 9'd224;

	localparam logic [ACTION_W-1:0] ACT_FILTER = 2'd0;
	localparam logic [ACTION_W-1:0] ACT_COEF   = 2'd1;
	localparam logic [ACTION_W-1:0] ACT_CLEAR  = 2'd2;

	typedef struct packed {
		logic start;
		logic issue;
		logic use_tap;
	} mac_ctl_t;

endpackage

>>> rtl/plf_ram.sv
module plf_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

>>> rtl/plf_mac.sv
module plf_mac
	import plf_pkg::*;
#(
	parameter int ACC_W = 50
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  mac_ctl_t                   ctl,
	input  logic signed [SAMPLE_W-1:0] hist_data,
	input  logic signed [COEF_W-1:0]   coef_data,
	output logic signed [ACC_W-1:0]    acc,
	output logic                       busy
);

	logic                     v_s1;
	logic                     use_s1;
	logic                     v_s2;
	logic signed [PROD_W-1:0] prod_s2;
	logic signed [ACC_W-1:0]  acc_q;

	// read data lands in the cycle after issue; align the flags with it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1   <= 1'b0;
			use_s1 <= 1'b0;
			v_s2   <= 1'b0;
		end else begin
			v_s1   <= ctl.issue;
			use_s1 <= ctl.use_tap;
			v_s2   <= v_s1;
		end
	end

	// drop taps older than the stored history
	always_ff @(posedge clk) begin
		if (v_s1) begin
			prod_s2 <= use_s1 ? PROD_W'(hist_data * coef_data) : '0;
		end
		if (ctl.start) begin
			acc_q <= '0;
		end else if (v_s2) begin
			acc_q <= acc_q + ACC_W'(prod_s2);
		end
	end

	assign acc  = acc_q;
	assign busy = v_s1 | v_s2;

endmodule

>>> rtl/phased_lowpass_fir.sv
// Filter request: one multiply-accumulate per kept tap (every fourth, from j0) on the one
// shared multiplier, then read latency, drain and output. Coefficient, clear and unused
// requests finish in the cycle they are taken.
// One request at a time; the next is taken once the result sits in the output register.
// Reset (arst_n low) empties history, clears phase and loads a tap count of 224, then a
// sweep over every address zeroes the coefficient memory; no request is taken meanwhile.
module phased_lowpass_fir
	import plf_pkg::*;
#(
	parameter int MAX_TAPS       = 256,
	parameter int COEF_FRAC_BITS = 17
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic [ACTION_W-1:0]        action,
	input  logic signed [SAMPLE_W-1:0] sample_in,
	input  logic [INDEX_W-1:0]         coef_index,
	input  logic signed [COEF_W-1:0]   coef_value,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic signed [OUT_W-1:0]    sample_out,
	input  logic                       cfg_write_en,
	input  logic [TAP_W-1:0]           cfg_write_data
);

	localparam int AW    = $clog2(MAX_TAPS);
	localparam int PW    = AW + 1;
	localparam int KW    = $clog2(MAX_TAPS + 1);
	localparam int CW    = INDEX_W + AW + 1;
	localparam int TW    = TAP_W + KW;
	localparam int ACC_W = PROD_W + AW;
	localparam int SH    = COEF_FRAC_BITS - 2;

	localparam logic [ACC_W-1:0] BIAS = ACC_W'((64'd1 << SH) - 64'd1);
	localparam logic signed [ACC_W-1:0] OUT_MAX =
		{{(ACC_W-OUT_W+1){1'b0}}, {(OUT_W-1){1'b1}}};
	localparam logic signed [ACC_W-1:0] OUT_MIN =
		{{(ACC_W-OUT_W+1){1'b1}}, {(OUT_W-1){1'b0}}};

	localparam logic [2:0] ST_CLR   = 3'd0;
	localparam logic [2:0] ST_IDLE  = 3'd1;
	localparam logic [2:0] ST_MAC   = 3'd2;
	localparam logic [2:0] ST_DRAIN = 3'd3;
	localparam logic [2:0] ST_DONE  = 3'd4;

	logic [2:0]                state_q;
	logic [TAP_W-1:0]          tap_count_q;
	logic [AW-1:0]             head_q;
	logic [KW-1:0]             fill_q;
	logic [1:0]                phase_q;
	logic [AW-1:0]             sweep_q;
	logic [AW-1:0]             coef_addr_q;
	logic [AW-1:0]             pos_q;
	logic [KW-1:0]             age_q;
	logic [SAMPLE_W-1:0]       sample_q;
	logic                      out_valid_q;
	logic signed [OUT_W-1:0]   sample_out_q;

	logic                      accept;
	logic                      out_free;
	logic [KW-1:0]             k_eff;
	logic [1:0]                j0;
	logic                      has_taps;
	logic [KW-1:0]             age0;
	logic [PW-1:0]             pos_sum;
	logic [AW-1:0]             pos0;
	logic [PW-1:0]             pos_inc;
	logic [AW-1:0]             pos_next;
	logic                      coef_in_range;
	logic                      coef_we;
	logic [AW-1:0]             coef_waddr;
	logic [COEF_W-1:0]         coef_wdata;
	logic [COEF_W-1:0]         coef_rdata;
	logic                      hist_we;
	logic [SAMPLE_W-1:0]       hist_rdata;
	mac_ctl_t                  mac_ctl;
	logic signed [ACC_W-1:0]   acc;
	logic                      mac_busy;
	logic signed [ACC_W-1:0]   quot;
	logic signed [OUT_W-1:0]   result;

	assign in_ready = (state_q == ST_IDLE);
	assign accept   = in_valid & in_ready;
	assign out_free = ~out_valid_q | out_ready;

	// window setup: the oldest tap used sits age0 samples behind the head
	always_comb begin
		if ({{KW{1'b0}}, tap_count_q} > TW'(MAX_TAPS)) begin
			k_eff = KW'(MAX_TAPS);
		end else begin
			k_eff = KW'(tap_count_q);
		end
		j0       = 2'd0 - phase_q;
		has_taps = k_eff > KW'(j0);
		age0     = k_eff - KW'(j0);
		pos_sum  = PW'(head_q) + PW'(MAX_TAPS) - PW'(age0);
		if (pos_sum >= PW'(MAX_TAPS)) begin
			pos0 = AW'(pos_sum - PW'(MAX_TAPS));
		end else begin
			pos0 = AW'(pos_sum);
		end
		pos_inc = PW'(pos_q) + PW'(4);
		if (pos_inc >= PW'(MAX_TAPS)) begin
			pos_next = AW'(pos_inc - PW'(MAX_TAPS));
		end else begin
			pos_next = AW'(pos_inc);
		end
	end

	assign coef_in_range = CW'(coef_index) < CW'(MAX_TAPS);

	always_comb begin
		if (state_q == ST_CLR) begin
			coef_we    = 1'b1;
			coef_waddr = sweep_q;
			coef_wdata = '0;
		end else begin
			coef_we    = accept & (action == ACT_COEF) & coef_in_range;
			coef_waddr = AW'(coef_index);
			coef_wdata = coef_value;
		end
	end

	assign hist_we = (state_q == ST_DONE) & out_free;

	always_comb begin
		mac_ctl.start   = accept & (action == ACT_FILTER);
		mac_ctl.issue   = (state_q == ST_MAC);
		mac_ctl.use_tap = (state_q == ST_MAC) & (age_q <= fill_q);
	end

	// truncate toward zero, then saturate
	always_comb begin
		quot = $signed(acc + (acc[ACC_W-1] ? BIAS : '0)) >>> SH;
		if (quot > OUT_MAX) begin
			result = OUT_W'(OUT_MAX);
		end else if (quot < OUT_MIN) begin
			result = OUT_W'(OUT_MIN);
		end else begin
			result = OUT_W'(quot);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLR;
			tap_count_q <= TAP_RESET;
			head_q      <= '0;
			fill_q      <= '0;
			phase_q     <= '0;
			sweep_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_write_en) begin
				tap_count_q <= cfg_write_data;
			end
			if (out_valid_q && out_ready && state_q != ST_DONE) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_CLR: begin
					sweep_q <= sweep_q + AW'(1);
					if (sweep_q == AW'(MAX_TAPS - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (accept) begin
						case (action)
							ACT_FILTER: begin
								state_q <= has_taps ? ST_MAC : ST_DONE;
							end
							ACT_CLEAR: begin
								head_q  <= '0;
								fill_q  <= '0;
								phase_q <= '0;
							end
							default: ;
						endcase
					end
				end
				ST_MAC: begin
					if (age_q <= KW'(4)) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					if (!mac_busy) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						head_q      <= (head_q == AW'(MAX_TAPS - 1)) ? '0 : head_q + AW'(1);
						if (fill_q < KW'(MAX_TAPS)) begin
							fill_q <= fill_q + KW'(1);
						end
						phase_q     <= phase_q + 2'd1;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// tap walk: advance one kept tap per cycle, every fourth coefficient
	always_ff @(posedge clk) begin
		if (accept && action == ACT_FILTER) begin
			sample_q    <= sample_in;
			coef_addr_q <= AW'(j0);
			pos_q       <= pos0;
			age_q       <= age0;
		end else if (state_q == ST_MAC) begin
			coef_addr_q <= coef_addr_q + AW'(4);
			pos_q       <= pos_next;
			age_q       <= (age_q > KW'(4)) ? age_q - KW'(4) : '0;
		end
		if (state_q == ST_DONE && out_free) begin
			sample_out_q <= result;
		end
	end

	plf_ram #(
		.WIDTH (COEF_W),
		.DEPTH (MAX_TAPS)
	) u_coef_ram (
		.clk   (clk),
		.we    (coef_we),
		.waddr (coef_waddr),
		.wdata (coef_wdata),
		.raddr (coef_addr_q),
		.rdata (coef_rdata)
	);

	plf_ram #(
		.WIDTH (SAMPLE_W),
		.DEPTH (MAX_TAPS)
	) u_hist_ram (
		.clk   (clk),
		.we    (hist_we),
		.waddr (head_q),
		.wdata (sample_q),
		.raddr (pos_q),
		.rdata (hist_rdata)
	);

	plf_mac #(
		.ACC_W (ACC_W)
	) u_mac (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (mac_ctl),
		.hist_data ($signed(hist_rdata)),
		.coef_data ($signed(coef_rdata)),
		.acc       (acc),
		.busy      (mac_busy)
	);

	assign out_valid  = out_valid_q;
	assign sample_out = sample_out_q;

endmodule

>>> rtl/plf_checker.sv
module plf_checker
	import plf_pkg::*;
(
	input logic                       clk,
	input logic                       arst_n,
	input logic                       in_valid,
	input logic                       in_ready,
	input logic [ACTION_W-1:0]        action,
	input logic                       out_valid,
	input logic                       out_ready,
	input logic signed [OUT_W-1:0]    sample_out
);

	// a filter request drops ready in the cycle after it is taken
	assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && action == ACT_FILTER |=> !in_ready)
		else $error("filter request did not drop ready");

	// other requests finish in the cycle they are taken
	assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && action != ACT_FILTER |=> in_ready)
		else $error("non-filter request held the block");

	// a new result only appears while a filter request is in progress
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(!in_ready))
		else $error("result appeared without a request in progress");

	// a stalled result holds
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(sample_out))
		else $error("stalled result changed");

endmodule

bind phased_lowpass_fir plf_checker u_plf_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (in_valid),
	.in_ready   (in_ready),
	.action     (action),
	.out_valid  (out_valid),
	.out_ready  (out_ready),
	.sample_out (sample_out)
);

>>> dv/fir_output_check.sv
`timescale 1ns / 1ps

module fir_output_check
	import plf_pkg::*;
#(
	parameter int MAX_TAPS       = 256,
	parameter int COEF_FRAC_BITS = 17
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	input  logic                       in_ready,
	input  logic [ACTION_W-1:0]        action,
	input  logic signed [SAMPLE_W-1:0] sample_in,
	input  logic [INDEX_W-1:0]         coef_index,
	input  logic signed [COEF_W-1:0]   coef_value,
	input  logic                       out_valid,
	input  logic                       out_ready,
	input  logic signed [OUT_W-1:0]    sample_out,
	input  logic                       cfg_write_en,
	input  logic [TAP_W-1:0]           cfg_write_data,
	output int                         fail_count,
	output int                         results_pending
);

	localparam longint OUT_MAX = (longint'(1) <<< (OUT_W - 1)) - 1;
	localparam longint OUT_MIN = -(longint'(1) <<< (OUT_W - 1));

	logic [TAP_W-1:0]           tap_count;
	logic signed [SAMPLE_W-1:0] hist_mem [MAX_TAPS];
	logic signed [COEF_W-1:0]   coef_mem [MAX_TAPS];
	int                         head;
	logic [1:0]                 phase;
	logic signed [OUT_W-1:0]    pending_outputs [$];
	logic signed [OUT_W-1:0]    want;

	initial begin
		fail_count = 0;
		results_pending = 0;
	end

	// Zero-stuffed polyphase sum over the last K stored samples; the
	// incoming sample is not part of it.
	function automatic logic signed [OUT_W-1:0] fir_output();
		int     k;
		int     j;
		int     pos;
		longint acc;
		longint y;
		k = int'(tap_count);
		if (k > MAX_TAPS)
			k = MAX_TAPS;
		acc = 0;
		for (j = (4 - int'(phase)) % 4; j < k; j += 4) begin
			pos = (head + MAX_TAPS - k + j) % MAX_TAPS;
			acc += longint'(coef_mem[j]) * longint'(hist_mem[pos]);
		end
		y = acc / (longint'(1) <<< (COEF_FRAC_BITS - 2));
		if (y > OUT_MAX)
			y = OUT_MAX;
		if (y < OUT_MIN)
			y = OUT_MIN;
		return OUT_W'(y);
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tap_count = TAP_RESET;
			for (int i = 0; i < MAX_TAPS; i++) begin
				hist_mem[i] = '0;
				coef_mem[i] = '0;
			end
			head = 0;
			phase = '0;
			pending_outputs.delete();
		end else begin
			if (cfg_write_en)
				tap_count = cfg_write_data;
			if (in_valid && in_ready) begin
				case (action)
					ACT_FILTER: begin
						pending_outputs.push_back(fir_output());
						hist_mem[head] = sample_in;
						head = (head + 1) % MAX_TAPS;
						phase = phase + 2'd1;
					end
					ACT_COEF: begin
						// drop slots beyond the table
						if (int'(coef_index) < MAX_TAPS)
							coef_mem[coef_index] = coef_value;
					end
					ACT_CLEAR: begin
						for (int i = 0; i < MAX_TAPS; i++)
							hist_mem[i] = '0;
						head = 0;
						phase = '0;
					end
					default: ;
				endcase
			end
			if (out_valid && out_ready) begin
				if (pending_outputs.size() == 0) begin
					fail_count++;
					$display("%0t: sample_out expected none, got %0d", $time, sample_out);
				end else begin
					want = pending_outputs.pop_front();
					if (sample_out !== want) begin
						fail_count++;
						$display("%0t: sample_out expected %0d, got %0d", $time, want,
							sample_out);
					end
				end
			end
		end
		results_pending = pending_outputs.size();
	end

endmodule

>>> dv/testbench.sv
`timescale 1ns / 1ps

module testbench;
	import plf_pkg::*;

	localparam int MAX_TAPS = 256;

	localparam logic [ACTION_W-1:0] ACT_UNUSED = 2'd3;

	localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = 24'sh7FFFFF;
	localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = 24'sh800000;
	localparam logic signed [COEF_W-1:0]   COEF_MAX   = 18'sh1FFFF;
	localparam logic signed [COEF_W-1:0]   COEF_MIN   = 18'sh20000;

	logic                       clk            = 1'b0;
	logic                       arst_n         = 1'b0;
	logic                       in_valid       = 1'b0;
	logic [ACTION_W-1:0]        action         = ACT_FILTER;
	logic signed [SAMPLE_W-1:0] sample_in      = '0;
	logic [INDEX_W-1:0]         coef_index     = '0;
	logic signed [COEF_W-1:0]   coef_value     = '0;
	logic                       out_ready      = 1'b1;
	logic                       cfg_write_en   = 1'b0;
	logic [TAP_W-1:0]           cfg_write_data = '0;
	logic                       in_ready;
	logic                       out_valid;
	logic signed [OUT_W-1:0]    sample_out;
	int                         fail_count;
	int                         results_pending;
	bit                         calm = 1'b0;

	phased_lowpass_fir uut (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.action        (action),
		.sample_in     (sample_in),
		.coef_index    (coef_index),
		.coef_value    (coef_value),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.sample_out    (sample_out),
		.cfg_write_en  (cfg_write_en),
		.cfg_write_data(cfg_write_data)
	);

	fir_output_check output_check (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.action         (action),
		.sample_in      (sample_in),
		.coef_index     (coef_index),
		.coef_value     (coef_value),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.sample_out     (sample_out),
		.cfg_write_en   (cfg_write_en),
		.cfg_write_data (cfg_write_data),
		.fail_count     (fail_count),
		.results_pending(results_pending)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	initial begin
		#10_000_000;
		$display("CHECK FAILED");
		$finish;
	end

	// Output side: stall in short bursts until the run turns calm.
	initial begin
		forever begin
			repeat ($urandom_range(1, 30)) @(posedge clk);
			if (!calm) begin
				out_ready <= 1'b0;
				repeat ($urandom_range(1, 5)) @(posedge clk);
				out_ready <= 1'b1;
			end
		end
	end

	task automatic send_request(input logic [ACTION_W-1:0] act,
		input logic signed [SAMPLE_W-1:0] smp, input logic [INDEX_W-1:0] idx,
		input logic signed [COEF_W-1:0] cv);
		if (!calm && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 5)) @(posedge clk);
		end
		in_valid   <= 1'b1;
		action     <= act;
		sample_in  <= smp;
		coef_index <= idx;
		coef_value <= cv;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
	endtask

	task automatic send_random(input int taps);
		int                         pick;
		int                         span;
		logic [ACTION_W-1:0]        act;
		logic signed [SAMPLE_W-1:0] smp;
		logic [INDEX_W-1:0]         idx;
		logic signed [COEF_W-1:0]   cv;
		pick = $urandom_range(0, 99);
		if (pick < 78)
			act = ACT_FILTER;
		else if (pick < 96)
			act = ACT_COEF;
		else if (pick < 97)
			act = ACT_CLEAR;
		else
			act = ACT_UNUSED;
		case ($urandom_range(0, 3))
			0: smp = $urandom_range(0, 1) ? SAMPLE_MAX : SAMPLE_MIN;
			1: smp = SAMPLE_W'($urandom_range(0, 4000)) - 24'd2000;
			default: smp = SAMPLE_W'($urandom);
		endcase
		// aim most coefficient writes at taps that are in use
		span = (taps > MAX_TAPS) ? MAX_TAPS : taps;
		if (span > 0 && $urandom_range(0, 3) != 0)
			idx = INDEX_W'($urandom_range(0, span - 1));
		else
			idx = INDEX_W'($urandom);
		if ($urandom_range(0, 5) == 0)
			cv = $urandom_range(0, 1) ? COEF_MAX : COEF_MIN;
		else
			cv = COEF_W'($urandom);
		send_request(act, smp, idx, cv);
	endtask

	// Hold off new requests until every filter result is back, then let any
	// coefficient or clear request finish.
	task automatic drain_results();
		in_valid <= 1'b0;
		@(negedge clk);
		while (results_pending != 0) @(negedge clk);
		repeat (16) @(posedge clk);
	endtask

	task automatic write_taps(input logic [TAP_W-1:0] taps);
		cfg_write_en   <= 1'b1;
		cfg_write_data <= taps;
		@(posedge clk);
		cfg_write_en   <= 1'b0;
	endtask

	task automatic run_phase(input int taps, input int count);
		drain_results();
		write_taps(TAP_W'(taps));
		if ($urandom_range(0, 1))
			send_request(ACT_CLEAR, SAMPLE_W'($urandom), INDEX_W'($urandom),
				COEF_W'($urandom));
		repeat (count) send_random(taps);
	endtask

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		// reset tap count, field extremes, unused action and clear
		send_request(ACT_COEF, SAMPLE_W'($urandom), 8'd0, COEF_MAX);
		send_request(ACT_COEF, SAMPLE_W'($urandom), 8'd1, COEF_MIN);
		send_request(ACT_COEF, SAMPLE_W'($urandom), 8'd2, 18'sd1);
		send_request(ACT_COEF, SAMPLE_W'($urandom), 8'd3, -18'sd1);
		send_request(ACT_COEF, SAMPLE_W'($urandom), 8'd255, 18'sh15555);
		send_request(ACT_COEF, SAMPLE_W'($urandom), 8'd223, COEF_MIN);
		send_request(ACT_FILTER, SAMPLE_MAX, 8'd0, '0);
		send_request(ACT_FILTER, SAMPLE_MIN, 8'hFF, 18'h3FFFF);
		send_request(ACT_FILTER, 24'sd0, 8'd0, '0);
		send_request(ACT_FILTER, 24'sd1, 8'd0, '0);
		send_request(ACT_FILTER, -24'sd1, 8'd0, '0);
		send_request(ACT_UNUSED, 24'hFFFFFF, 8'hFF, 18'h3FFFF);
		send_request(ACT_FILTER, 24'sh555555, 8'h55, 18'h15555);
		send_request(ACT_CLEAR, 24'hFFFFFF, 8'hFF, 18'h3FFFF);
		send_request(ACT_FILTER, SAMPLE_MIN, 8'd0, '0);
		send_request(ACT_FILTER, SAMPLE_MAX, 8'd0, '0);
		send_request(ACT_COEF, 24'sd0, 8'd4, 18'sd0);
		send_request(ACT_FILTER, 24'shAAAAAA, 8'hAA, 18'h2AAAA);
		send_request(ACT_UNUSED, '0, '0, '0);
		send_request(ACT_FILTER, 24'sd0, 8'd0, '0);

		run_phase(16, 150);
		run_phase(0, 50);
		run_phase(5, 120);
		run_phase(13, 120);
		run_phase(256, 150);

		// every used product at its largest: the sum must saturate high
		drain_results();
		write_taps(9'd256);
		for (int i = 0; i < MAX_TAPS; i++)
			send_request(ACT_COEF, SAMPLE_W'($urandom), INDEX_W'(i), COEF_MIN);
		send_request(ACT_CLEAR, SAMPLE_W'($urandom), INDEX_W'($urandom), COEF_W'($urandom));
		repeat (280) send_request(ACT_FILTER, SAMPLE_MIN, INDEX_W'($urandom),
			COEF_W'($urandom));

		run_phase(511, 120);
		run_phase(100, 120);
		run_phase($urandom_range(1, 511), 120);
		calm = 1'b1;
		run_phase(224, 150);

		drain_results();
		repeat (80) @(posedge clk);
		if (fail_count == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
